[rtl/positional_list_engine_macros.svh]
// Assertion macros used by the positional list engine datapath.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PLE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("positional list engine check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("positional list engine check failed");

`endif

[rtl/ple_pkg.sv]
// Shared types and constants of the positional list engine.
package ple_pkg;

   localparam int unsigned CAPACITY_DEF = 128;
   localparam int unsigned FUNC_W       = 3;
   localparam int unsigned POS_W        = 8;
   localparam int unsigned WORD_W       = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 3'd0,
      FUNC_DELETE = 3'd1,
      FUNC_GET    = 3'd2,
      FUNC_FIND   = 3'd3,
      FUNC_CLEAR  = 3'd4
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_CHK,
      ST_INS_MOVE,
      ST_DEL_CAP,
      ST_DEL_CHK,
      ST_DEL_MOVE,
      ST_GET_CAP,
      ST_FIND_CHK,
      ST_FIND_CMP,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_DEC,
      RD_INC,
      RD_POSM1
   } rd_sel_type;

   typedef enum logic [1:0] {
      LD_COUNT,
      LD_POSM1,
      LD_ZERO
   } ld_sel_type;

   typedef struct packed {
      logic       accept;
      logic       idx_load;
      ld_sel_type ld_sel;
      logic       idx_inc;
      logic       idx_dec;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      logic       wr_val;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       cnt_clr;
      logic       set_ok;
      logic       cap_value;
      logic       set_found;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     ins_ok;
      logic     acc_ok;
      logic     idx_ge_pos;
      logic     idx_next_lt_cnt;
      logic     idx_lt_cnt;
      logic     match;
      logic     rsp_free;
   } status_type;

endpackage

[rtl/ple_ctrl.sv]
// Controller state machine of the positional list engine.
module ple_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ple_pkg::status_type status,
   output ple_pkg::cmd_type    cmd
);
   import ple_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (status.func)
               FUNC_INSERT: state_in = status.ins_ok ? ST_INS_CHK : ST_RESP;
               FUNC_DELETE: state_in = status.acc_ok ? ST_DEL_CAP : ST_RESP;
               FUNC_GET:    state_in = status.acc_ok ? ST_GET_CAP : ST_RESP;
               FUNC_FIND:   state_in = ST_FIND_CHK;
               default:     state_in = ST_RESP;
            endcase
         end
         ST_INS_CHK:  state_in = status.idx_ge_pos ? ST_INS_MOVE : ST_RESP;
         ST_INS_MOVE: state_in = ST_INS_CHK;
         ST_DEL_CAP:  state_in = ST_DEL_CHK;
         ST_DEL_CHK:  state_in = status.idx_next_lt_cnt ? ST_DEL_MOVE : ST_RESP;
         ST_DEL_MOVE: state_in = ST_DEL_CHK;
         ST_GET_CAP:  state_in = ST_RESP;
         ST_FIND_CHK: state_in = status.idx_lt_cnt ? ST_FIND_CMP : ST_RESP;
         ST_FIND_CMP: state_in = status.match ? ST_RESP : ST_FIND_CHK;
         ST_RESP: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.ld_sel = LD_ZERO;
      cmd.rd_sel = RD_IDX;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
         end
         ST_DECODE: begin
            unique case (status.func)
               FUNC_INSERT: begin
                  cmd.idx_load = status.ins_ok;
                  cmd.ld_sel   = LD_COUNT;
               end
               FUNC_DELETE, FUNC_GET: begin
                  cmd.idx_load = status.acc_ok;
                  cmd.ld_sel   = LD_POSM1;
                  cmd.rd_en    = status.acc_ok;
                  cmd.rd_sel   = RD_POSM1;
               end
               FUNC_FIND: begin
                  cmd.idx_load = 1'b1;
                  cmd.ld_sel   = LD_ZERO;
                  cmd.set_ok   = 1'b1;
               end
               FUNC_CLEAR: begin
                  cmd.cnt_clr = 1'b1;
                  cmd.set_ok  = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_INS_CHK: begin
            if (status.idx_ge_pos) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_DEC;
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_val  = 1'b1;
               cmd.cnt_inc = 1'b1;
               cmd.set_ok  = 1'b1;
            end
         end
         ST_INS_MOVE: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_dec = 1'b1;
         end
         ST_DEL_CAP: begin
            cmd.cap_value = 1'b1;
            cmd.set_ok    = 1'b1;
         end
         ST_DEL_CHK: begin
            if (status.idx_next_lt_cnt) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_INC;
            end else begin
               cmd.cnt_dec = 1'b1;
            end
         end
         ST_DEL_MOVE: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         ST_GET_CAP: begin
            cmd.cap_value = 1'b1;
            cmd.set_ok    = 1'b1;
         end
         ST_FIND_CHK: begin
            cmd.rd_en  = status.idx_lt_cnt;
            cmd.rd_sel = RD_IDX;
         end
         ST_FIND_CMP: begin
            cmd.set_found = status.match;
            cmd.idx_inc   = !status.match;
         end
         ST_RESP: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/ple_dpath.sv]
// Datapath of the positional list engine: entry memory, length, index and result.
`include "positional_list_engine_macros.svh"

module ple_dpath #(
   parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [ple_pkg::FUNC_W-1:0]           req_func,
   input  logic [ple_pkg::POS_W-1:0]            req_position,
   input  logic signed [ple_pkg::WORD_W-1:0]    req_value,
   input  logic                                 rsp_stall,
   input  ple_pkg::cmd_type                     cmd,
   output ple_pkg::status_type                  status,
   output logic                                 rsp_valid,
   output logic                                 rsp_ok,
   output logic signed [ple_pkg::WORD_W-1:0]    rsp_value_out,
   output logic [ple_pkg::POS_W-1:0]            rsp_found_position,
   output logic [ple_pkg::POS_W-1:0]            rsp_list_length
);
   import ple_pkg::*;

   localparam int unsigned CW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned LW    = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = ((LW > POS_W) ? LW : POS_W) + 1;

   logic [WORD_W-1:0] mem [CAPACITY];

   logic [FUNC_W-1:0] func_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [WORD_W-1:0] val_ff;
   logic [WORD_W-1:0] rd_data_ff;
   logic [LW-1:0]     count_ff, count_in;
   logic [LW-1:0]     idx_ff, idx_in;
   logic              res_ok_ff, res_ok_in;
   logic [WORD_W-1:0] res_value_ff, res_value_in;
   logic [POS_W-1:0]  res_found_ff, res_found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff;
   logic [WORD_W-1:0] rsp_value_ff;
   logic [POS_W-1:0]  rsp_found_ff;
   logic [POS_W-1:0]  rsp_len_ff;

   logic [CMP_W-1:0]  pos_c, cnt_c, idx_c, cap_c, idx_p1;
   logic [POS_W-1:0]  pos_m1;
   logic [CW-1:0]     rd_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rsp_free;

   assign pos_c  = CMP_W'(pos_ff);
   assign cnt_c  = CMP_W'(count_ff);
   assign idx_c  = CMP_W'(idx_ff);
   assign cap_c  = CMP_W'(CAPACITY);
   assign idx_p1 = idx_c + CMP_W'(1);
   assign pos_m1 = pos_ff - POS_W'(1);

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign status.func            = func_type'(func_ff);
   assign status.ins_ok          = (cnt_c < cap_c) && (pos_c != '0)
                                   && (pos_c <= cnt_c + CMP_W'(1));
   assign status.acc_ok          = (pos_c != '0) && (pos_c <= cnt_c);
   assign status.idx_ge_pos      = (idx_c >= pos_c);
   assign status.idx_next_lt_cnt = (idx_p1 < cnt_c);
   assign status.idx_lt_cnt      = (idx_c < cnt_c);
   assign status.match           = (rd_data_ff == val_ff);
   assign status.rsp_free        = rsp_free;

   always_comb begin
      case (cmd.rd_sel)
         RD_IDX:   rd_addr = idx_ff[CW-1:0];
         RD_DEC:   rd_addr = CW'(idx_ff - LW'(1));
         RD_INC:   rd_addr = CW'(idx_ff + LW'(1));
         RD_POSM1: rd_addr = CW'(pos_m1);
         default:  rd_addr = idx_ff[CW-1:0];
      endcase
   end

   assign wr_data = cmd.wr_val ? val_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) mem[idx_ff[CW-1:0]] <= wr_data;
      if (cmd.rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_load) begin
         case (cmd.ld_sel)
            LD_COUNT: idx_in = count_ff;
            LD_POSM1: idx_in = LW'(pos_m1);
            default:  idx_in = '0;
         endcase
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + LW'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - LW'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_clr)      count_in = '0;
      else if (cmd.cnt_inc) count_in = count_ff + LW'(1);
      else if (cmd.cnt_dec) count_in = count_ff - LW'(1);
   end

   always_comb begin
      res_ok_in    = res_ok_ff;
      res_value_in = res_value_ff;
      res_found_in = res_found_ff;
      if (cmd.accept) begin
         res_ok_in    = 1'b0;
         res_value_in = '0;
         res_found_in = '0;
      end else begin
         if (cmd.set_ok)    res_ok_in    = 1'b1;
         if (cmd.cap_value) res_value_in = rd_data_ff;
         if (cmd.set_found) res_found_in = idx_p1[POS_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load)  rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      res_ok_ff    <= res_ok_in;
      res_value_ff <= res_value_in;
      res_found_ff <= res_found_in;
      if (cmd.accept) begin
         func_ff <= req_func;
         pos_ff  <= req_position;
         val_ff  <= req_value;
      end
      if (cmd.rsp_load) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_value_ff <= res_value_ff;
         rsp_found_ff <= res_found_ff;
         rsp_len_ff   <= POS_W'(count_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_value_out      = rsp_value_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_list_length    = rsp_len_ff;

   `PLE_ASSERT_NOW(a_count_bound, 1'b1, cnt_c <= cap_c)
   `PLE_ASSERT_NOW(a_inc_room, cmd.cnt_inc, cnt_c < cap_c)
   `PLE_ASSERT_NOW(a_dec_nonempty, cmd.cnt_dec, count_ff != '0)
   `PLE_ASSERT_NOW(a_wr_in_range, cmd.wr_en, idx_c < cap_c)
   `PLE_ASSERT_NEXT(a_load_shows, cmd.rsp_load, rsp_valid_ff)

endmodule

[rtl/positional_list_engine.sv]
// Top level of the positional list engine.
// Ordered list of up to CAPACITY signed 32-bit entries in an entry memory
// with one write port and one registered read port (one write and one
// registered read per cycle). One request is worked on at a time. Clear,
// unknown operations and rejected requests go from decode straight to the
// response; get reads one entry, insert and delete shift the entries behind
// the position, and find compares entries from the front until a match or
// the end of the list. The next request is taken in the cycle after the
// load at the earliest. Every shift or compare step first reads an entry
// through the memory read port and then writes or compares it. A new
// request is taken while an earlier response still waits in the output
// register. There is no clearing pass after reset; entries hold whatever
// was last written, and only written ones are ever read.
module positional_list_engine #(
   parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ple_pkg::FUNC_W-1:0]        req_func,
   input  logic [ple_pkg::POS_W-1:0]         req_position,
   input  logic signed [ple_pkg::WORD_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_ok,
   output logic signed [ple_pkg::WORD_W-1:0] rsp_value_out,
   output logic [ple_pkg::POS_W-1:0]         rsp_found_position,
   output logic [ple_pkg::POS_W-1:0]         rsp_list_length
);
   import ple_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequence each request: decode, a shift or scan loop where needed, respond
   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hold entries, length, loop index and the response register
   ple_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_func           (req_func),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_stall          (rsp_stall),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_value_out      (rsp_value_out),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length)
   );

endmodule
